FILE: rtl/sacsr_pkg.sv
// ----------------------------------------------------------------------------
// sacsr_pkg
// shared constants and types of the signature replacement cache core
// ----------------------------------------------------------------------------
package sacsr_pkg;

    localparam int DEF_WAYS         = 16;
    localparam int DEF_SETS         = 2048;
    localparam int DEF_BLOCK_BYTES  = 64;
    localparam int DEF_SIG_BITS     = 16;
    localparam int DEF_COUNTER_BITS = 8;
    localparam int DEF_ADDR_BITS    = 48;

    localparam int FIELD_ADDR_W = 48;
    localparam int FIELD_TIME_W = 32;
    localparam int FIELD_WAY_W  = 4;
    localparam int USE_W        = 16;

    localparam logic POLICY_LRU = 1'b0;
    localparam logic POLICY_LFU = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DECIDE,
        S_DEC,
        S_WRITE
    } t_state;

endpackage

FILE: rtl/sacsr_ram.sv
// ----------------------------------------------------------------------------
// sacsr_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sacsr_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/set_assoc_cache_signature_replacement_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_signature_replacement_core
// set associative tag store with signature counters and lru / lfu victim choice
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | address, pc, is_store, timestamp
//  out     | output    | o_out_valid / i_out_ready | hit, way_used, writeback_needed, addr
//  cfg     | input     | i_cfg_valid / o_cfg_ready | policy_mode
//
//  an item passes through read, scan, decide, dec (only when an evicted line was
//  never reused) and write; the set row is scanned one way per cycle from a single
//  memory read. a new item is taken only in idle. after reset a clearing pass
//  runs before the first item is taken; cfg writes are taken at any time.
//  a full output register holds the item in its last step until taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_signature_replacement_core #(
    parameter int WAYS         = sacsr_pkg::DEF_WAYS,
    parameter int SETS         = sacsr_pkg::DEF_SETS,
    parameter int BLOCK_BYTES  = sacsr_pkg::DEF_BLOCK_BYTES,
    parameter int SIG_BITS     = sacsr_pkg::DEF_SIG_BITS,
    parameter int COUNTER_BITS = sacsr_pkg::DEF_COUNTER_BITS,
    parameter int ADDR_BITS    = sacsr_pkg::DEF_ADDR_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_policy_mode,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [47:0] i_address,
    input  logic [47:0] i_pc,
    input  logic        i_is_store,
    input  logic [sacsr_pkg::FIELD_TIME_W-1:0] i_timestamp,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hit,
    output logic [3:0]  o_way_used,
    output logic        o_writeback_needed,
    output logic [47:0] o_writeback_addr
);

    import sacsr_pkg::*;

    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int SET_W  = $clog2(SETS);
    localparam int TAG_W  = ADDR_BITS - OFF_W - SET_W;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int CLR_W  = (SET_W > SIG_BITS) ? SET_W : SIG_BITS;
    localparam int NSIGS  = 1 << SIG_BITS;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic                dirty;
        logic [31:0]         touch;
        logic [USE_W-1:0]    use_cnt;
        logic                reused;
        logic [SIG_BITS-1:0] sig;
    } t_line;

    typedef t_line [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    t_state r_state, n_state;

    logic [CLR_W-1:0]        r_clr;
    logic                    r_policy;
    t_row                    r_row;
    logic [COUNTER_BITS-1:0] r_ctr;
    logic [TAG_W-1:0]        r_tag;
    logic [SET_W-1:0]        r_set;
    logic [SIG_BITS-1:0]     r_sig;
    logic                    r_store;
    logic [31:0]             r_now;
    logic [WAY_W-1:0]        r_w;
    logic                    r_hit;
    logic [WAY_W-1:0]        r_hway;
    t_line                   r_hline;
    logic                    r_free;
    logic [WAY_W-1:0]        r_fway;
    logic [31:0]             r_min;
    logic [WAY_W-1:0]        r_vway;
    t_line                   r_vline;

    logic        r_out_valid;
    logic        r_out_hit;
    logic [3:0]  r_out_way;
    logic        r_out_wb;
    logic [47:0] r_out_wb_addr;

    // input decode
    logic [63:0]          a64;
    logic [ADDR_BITS-1:0] addr;
    assign a64  = 64'(i_address);
    assign addr = a64[ADDR_BITS-1:0];

    // memories
    logic                    row_we;
    logic [SET_W-1:0]        row_waddr;
    logic [ROW_W-1:0]        row_wdata;
    logic [SET_W-1:0]        row_raddr;
    logic [ROW_W-1:0]        row_rdata;
    logic                    ctr_we;
    logic [SIG_BITS-1:0]     ctr_waddr;
    logic [COUNTER_BITS-1:0] ctr_wdata;
    logic [SIG_BITS-1:0]     ctr_raddr;
    logic [COUNTER_BITS-1:0] ctr_rdata;

    sacsr_ram #(.W(ROW_W), .D(SETS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    sacsr_ram #(.W(COUNTER_BITS), .D(NSIGS)) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ctr_we),
        .i_waddr (ctr_waddr),
        .i_wdata (ctr_wdata),
        .i_raddr (ctr_raddr),
        .o_rdata (ctr_rdata)
    );

    // datapath helpers
    logic                    in_acc;
    logic                    out_free;
    logic                    clr_last;
    logic                    clr_row_on;
    logic                    clr_ctr_on;
    t_line                   cur;
    logic [31:0]             cur_key;
    logic                    need_dec;
    logic [COUNTER_BITS-1:0] ctr_dec;
    t_line                   new_line;
    t_row                    wr_row;
    logic [WAY_W-1:0]        fin_way;
    logic [ADDR_BITS-1:0]    wba;
    logic [63:0]             wb64;

    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign clr_last   = (r_clr == {CLR_W{1'b1}});
    assign clr_row_on = ({1'b0, r_clr} < (CLR_W+1)'(SETS));
    assign clr_ctr_on = ({1'b0, r_clr} < (CLR_W+1)'(NSIGS));
    assign cur        = r_row[r_w];
    assign cur_key    = (r_policy == POLICY_LFU) ? 32'(cur.use_cnt) : cur.touch;
    assign need_dec   = !r_hit && !r_free && !r_vline.reused;
    assign ctr_dec    = (ctr_rdata == '0) ? ctr_rdata : ctr_rdata - 1'b1;
    assign fin_way    = r_hit ? r_hway : (r_free ? r_fway : r_vway);
    assign wba        = {r_vline.tag, r_set, {OFF_W{1'b0}}};
    assign wb64       = 64'(wba);

    always_comb begin
        if (r_hit) begin
            new_line         = r_hline;
            new_line.touch   = r_now;
            new_line.use_cnt = (r_hline.use_cnt == '1) ? r_hline.use_cnt
                                                       : r_hline.use_cnt + 1'b1;
            new_line.reused  = 1'b1;
            new_line.dirty   = r_hline.dirty | r_store;
        end else begin
            new_line.valid   = 1'b1;
            new_line.tag     = r_tag;
            new_line.dirty   = r_store;
            new_line.touch   = r_now;
            new_line.use_cnt = USE_W'(r_ctr);
            new_line.reused  = 1'b0;
            new_line.sig     = r_sig;
        end
        wr_row          = r_row;
        wr_row[fin_way] = new_line;
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        row_we     = 1'b0;
        row_waddr  = r_set;
        row_wdata  = wr_row;
        row_raddr  = addr[OFF_W +: SET_W];
        ctr_we     = 1'b0;
        ctr_waddr  = r_sig;
        ctr_wdata  = (r_ctr == '1) ? r_ctr : r_ctr + 1'b1;
        ctr_raddr  = i_pc[SIG_BITS-1:0];
        case (r_state)
            S_CLEAR: begin
                row_we    = clr_row_on;
                row_waddr = r_clr[SET_W-1:0];
                row_wdata = '0;
                ctr_we    = clr_ctr_on;
                ctr_waddr = r_clr[SIG_BITS-1:0];
                ctr_wdata = '0;
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_w == WAY_W'(WAYS-1)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                ctr_raddr = r_vline.sig;
                n_state   = need_dec ? S_DEC : S_WRITE;
            end
            S_DEC: begin
                ctr_we    = 1'b1;
                ctr_waddr = r_vline.sig;
                ctr_wdata = ctr_dec;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    row_we  = 1'b1;
                    ctr_we  = r_hit;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_policy    <= POLICY_LRU;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid) begin
                r_policy <= i_cfg_policy_mode;
            end
            if (r_state == S_WRITE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tag   <= addr[ADDR_BITS-1 -: TAG_W];
            r_set   <= addr[OFF_W +: SET_W];
            r_sig   <= i_pc[SIG_BITS-1:0];
            r_store <= i_is_store;
            r_now   <= i_timestamp;
        end
        case (r_state)
            S_READ: begin
                r_row  <= row_rdata;
                r_ctr  <= ctr_rdata;
                r_w    <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end
            S_SCAN: begin
                r_w <= r_w + 1'b1;
                if (!r_hit && cur.valid && cur.tag == r_tag) begin
                    r_hit   <= 1'b1;
                    r_hway  <= r_w;
                    r_hline <= cur;
                end
                if (!r_free && !cur.valid) begin
                    r_free <= 1'b1;
                    r_fway <= r_w;
                end
                if (r_w == '0 || cur_key < r_min) begin
                    r_min   <= cur_key;
                    r_vway  <= r_w;
                    r_vline <= cur;
                end
            end
            S_DEC: begin
                if (r_vline.sig == r_sig) begin
                    r_ctr <= ctr_dec;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    r_out_hit     <= r_hit;
                    r_out_way     <= FIELD_WAY_W'(fin_way);
                    r_out_wb      <= !r_hit && !r_free;
                    r_out_wb_addr <= (!r_hit && !r_free) ? wb64[FIELD_ADDR_W-1:0] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_out_hit;
    assign o_way_used         = r_out_way;
    assign o_writeback_needed = r_out_wb;
    assign o_writeback_addr   = r_out_wb_addr;

    // checks
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_READ)
        else $error("accepted item did not start a set read");

    a_write_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && !out_free) |=> r_state == S_WRITE)
        else $error("write-back left while output register full");

    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> !o_writeback_needed)
        else $error("hit reported an eviction");

    a_wb_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_writeback_needed) |-> o_writeback_addr == '0)
        else $error("writeback address set without eviction");

endmodule

FILE: test/sacsr_checker.sv
// ----------------------------------------------------------------------------
// sacsr_checker
// watches the cfg, in and out channels of the cache core, keeps its own copy
// of the tag store and signature counters, and compares every result item
// ----------------------------------------------------------------------------
module sacsr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_policy_mode,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [47:0] i_address,
    input  logic [47:0] i_pc,
    input  logic        i_is_store,
    input  logic [31:0] i_timestamp,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_hit,
    input  logic [3:0]  i_way_used,
    input  logic        i_writeback_needed,
    input  logic [47:0] i_writeback_addr,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_hits,
    output int          o_evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAYS    = 16;
    localparam int SETS    = 2048;
    localparam int OFF_W   = 6;
    localparam int SET_W   = 11;
    localparam int NSIG    = 65536;
    localparam int CTR_MAX = 255;

    typedef struct packed {
        logic        hit;
        logic [3:0]  way;
        logic        wb;
        logic [47:0] wb_addr;
    } t_access_result;

    logic        line_valid [WAYS*SETS];
    logic [30:0] line_tag   [WAYS*SETS];
    logic        line_dirty [WAYS*SETS];
    logic [31:0] line_touch [WAYS*SETS];
    logic [15:0] line_uses  [WAYS*SETS];
    logic        line_reused[WAYS*SETS];
    logic [15:0] line_sig   [WAYS*SETS];
    logic [7:0]  sig_ctr    [NSIG];
    logic        policy;

    t_access_result expected_q[$];

    function automatic t_access_result predict_access(logic [47:0] addr, logic [47:0] pc,
                                                      logic store, logic [31:0] now);
        t_access_result r;
        logic [15:0] sig;
        logic [10:0] set;
        logic [30:0] tag;
        int base;
        int way;
        int i;
        bit found;
        sig = pc[15:0];
        set = addr[OFF_W +: SET_W];
        tag = addr[47:OFF_W+SET_W];
        base = int'(set) * WAYS;
        r = '0;
        found = 0;
        way = 0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && line_valid[base+w] && line_tag[base+w] == tag) begin
                found = 1;
                way = w;
            end
        end
        if (found) begin
            i = base + way;
            line_touch[i] = now;
            if (line_uses[i] != 16'hffff) line_uses[i]++;
            if (sig_ctr[sig] != CTR_MAX) sig_ctr[sig]++;
            line_reused[i] = 1;
            if (store) line_dirty[i] = 1;
        end else begin
            bit free_found;
            free_found = 0;
            for (int w = 0; w < WAYS; w++) begin
                if (!free_found && !line_valid[base+w]) begin
                    free_found = 1;
                    way = w;
                end
            end
            if (!free_found) begin
                way = 0;
                for (int w = 1; w < WAYS; w++) begin
                    if (policy == sacsr_pkg::POLICY_LRU) begin
                        if (line_touch[base+w] < line_touch[base+way]) way = w;
                    end else begin
                        if (line_uses[base+w] < line_uses[base+way]) way = w;
                    end
                end
                i = base + way;
                if (!line_reused[i] && sig_ctr[line_sig[i]] != 0) sig_ctr[line_sig[i]]--;
                r.wb = 1;
                r.wb_addr = {line_tag[i], set, 6'd0};
            end
            i = base + way;
            line_valid[i] = 1;
            line_tag[i] = tag;
            line_dirty[i] = store;
            line_touch[i] = now;
            line_uses[i] = {8'd0, sig_ctr[sig]};
            line_sig[i] = sig;
            line_reused[i] = 0;
        end
        r.hit = found;
        r.way = way[3:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_access_result want;
        if (!i_rst_n) begin
            o_errors = 0;
            o_results = 0;
            o_hits = 0;
            o_evictions = 0;
            policy = sacsr_pkg::POLICY_LRU;
            foreach (line_valid[k]) begin
                line_valid[k] = 0;
                line_reused[k] = 0;
            end
            foreach (sig_ctr[k]) sig_ctr[k] = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) policy = i_cfg_policy_mode;
            if (i_in_valid && i_in_ready)
                expected_q.push_back(predict_access(i_address, i_pc, i_is_store,
                                                    i_timestamp));
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    $display("unexpected result item at %0t", $realtime);
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.hit) o_hits++;
                    if (want.wb) o_evictions++;
                    if (i_hit !== want.hit) report_mismatch("hit", i_hit, want.hit);
                    if (i_way_used !== want.way)
                        report_mismatch("way_used", i_way_used, want.way);
                    if (i_writeback_needed !== want.wb)
                        report_mismatch("writeback_needed", i_writeback_needed, want.wb);
                    if (i_writeback_addr !== want.wb_addr)
                        report_mismatch("writeback_addr", i_writeback_addr, want.wb_addr);
                end
            end
        end
        o_pending = expected_q.size();
    end
endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives directed and random access items and policy writes into the cache
// core with random idling on both sides; the checker judges every result
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_policy_mode;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [47:0] i_address;
    logic [47:0] i_pc;
    logic        i_is_store;
    logic [31:0] i_timestamp;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_hit;
    logic [3:0]  o_way_used;
    logic        o_writeback_needed;
    logic [47:0] o_writeback_addr;

    int errors, pending, results, hits, evictions;
    int idle_pct;
    int idle_cycles;
    int sent;
    logic [31:0] clock_now;

    set_assoc_cache_signature_replacement_core u_dut (.*);

    sacsr_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_policy_mode,
        .i_in_valid, .i_in_ready(o_in_ready), .i_address, .i_pc, .i_is_store,
        .i_timestamp, .i_out_valid(o_out_valid), .i_out_ready, .i_hit(o_hit),
        .i_way_used(o_way_used), .i_writeback_needed(o_writeback_needed),
        .i_writeback_addr(o_writeback_addr), .o_errors(errors), .o_pending(pending),
        .o_results(results), .o_hits(hits), .o_evictions(evictions)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // receiver stalls
    always @(negedge i_clk) i_out_ready <= ($urandom_range(99) >= idle_pct);

    // watchdog on handshakes of the in, out and cfg channels
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d items outstanding", pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_policy(logic mode);
        i_in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_policy_mode <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_access(logic [47:0] addr, logic [47:0] pc, logic store,
                               logic [31:0] stamp);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_address <= addr;
        i_pc <= pc;
        i_is_store <= store;
        i_timestamp <= stamp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // address within a few hot sets so that sets fill and evict
    function automatic logic [47:0] hot_address(int set_pick, int tag_pick);
        logic [47:0] a;
        a = 48'({$urandom(), $urandom()});
        a[16:6] = 11'(set_pick);
        a[47:17] = 31'(tag_pick);
        return a;
    endfunction

    task automatic run_random(int count);
        logic [47:0] pc;
        for (int n = 0; n < count; n++) begin
            if (n == count / 3) idle_pct = 0;
            if (n == count / 2) idle_pct = 38;
            pc = 48'({$urandom(), $urandom()});
            if ($urandom_range(3) != 0) pc[15:0] = 16'($urandom_range(7));
            if ($urandom_range(9) == 0) begin
                send_access(48'({$urandom(), $urandom()}), pc, 1'($urandom_range(1)),
                            $urandom());
            end else begin
                clock_now += $urandom_range(3);
                send_access(hot_address($urandom_range(2) * 1023, $urandom_range(23)),
                            pc, 1'($urandom_range(1)),
                            ($urandom_range(15) == 0) ? $urandom() : clock_now);
            end
        end
    endtask

    initial begin
        idle_pct = 38;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_policy_mode = 0;
        i_in_valid = 0;
        i_address = '0;
        i_pc = '0;
        i_is_store = 0;
        i_timestamp = '0;
        sent = 0;
        clock_now = 100;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;

        // directed: fill one set past its ways, extremes, ties, wrap
        write_policy(sacsr_pkg::POLICY_LRU);
        send_access('0, '0, 1'b0, '0);
        send_access(48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 1'b1, 32'hffff_ffff);
        send_access('0, 48'hffff_ffff_ffff, 1'b1, 32'd5);
        for (int t = 1; t <= 17; t++)
            send_access(hot_address(5, t), 48'h1234_0000_0007, t[0], 32'd7);
        send_access(hot_address(5, 3), 48'h0000_0000_0009, 1'b0, 32'd9);
        send_access(hot_address(5, 40), 48'h0000_0000_0009, 1'b0, 32'h8000_0000);
        write_policy(sacsr_pkg::POLICY_LFU);
        send_access(hot_address(5, 41), 48'h0000_0000_0007, 1'b1, 32'd1);
        send_access(hot_address(5, 42), 48'h0000_0000_0007, 1'b0, 32'd2);

        run_random(170);
        write_policy(sacsr_pkg::POLICY_LRU);
        run_random(170);
        write_policy(sacsr_pkg::POLICY_LFU);
        run_random(170);

        i_in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("sent %0d access items over both victim policies: %0d results,",
                 sent, results);
        $display("%0d hits and %0d evictions", hits, evictions);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
